>>> rtl/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W      = COL_W + 1;
  localparam int LS_DEPTH   = MAX_WIDTH * 4;
  localparam int LS_AW      = $clog2(LS_DEPTH);

  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CHANNELS = 2'd2;

  localparam logic [1:0] K_PIX  = 2'd0;
  localparam logic [1:0] K_FILT = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  localparam logic [2:0] F_NONE  = 3'd0;
  localparam logic [2:0] F_SUB   = 3'd1;
  localparam logic [2:0] F_UP    = 3'd2;
  localparam logic [2:0] F_AVG   = 3'd3;
  localparam logic [2:0] F_PAETH = 3'd4;

  localparam logic [7:0] ALPHA_FILL = 8'd255;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [1:0]       ch;
    logic [2:0]       filt;
    logic             first_row;
    logic             two_out;
    logic             img_done;
    logic [LS_AW-1:0] addr;
  } s1_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       run_end;
    logic       image_end;
    logic       bad_filter;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> rtl/psu_ram.sv
`timescale 1ns / 1ps

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/psu_ctrl.sv
`timescale 1ns / 1ps

module psu_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [7:0]                       filtered_byte_i,
  output logic                             rd_en_o,
  output logic [psu_pkg::LS_AW-1:0]        rd_addr_o,
  output logic                             s1_valid_o,
  output psu_pkg::s1_t                     s1_o,
  output logic                             halt_o
);

  import psu_pkg::*;

  logic [12:0]      width_q;
  logic [15:0]      height_q;
  logic [2:0]       chans_q;

  logic [COL_W-1:0] col_q, col_d;
  logic [1:0]       ch_q, ch_d;
  logic [15:0]      row_q, row_d;
  logic [2:0]       filt_q, filt_d;
  logic             await_q, await_d;
  logic             halt_q, halt_d;

  logic             s1_valid_q;
  s1_t              s1_q, s1_d;

  logic             accept;
  logic [CNT_W-1:0] eff_w;
  logic [15:0]      eff_h;
  logic [2:0]       eff_ch;
  logic [CNT_W-1:0] col_inc;
  logic [16:0]      row_inc;
  logic [2:0]       ch_inc;
  logic             pix_done, row_done, img_done;

  assign accept = in_valid_i && !in_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 16'd1;
      chans_q  <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i[12:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i[15:0];
        CFG_COLOR_CHANNELS: chans_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == 13'd0) begin
      eff_w = CNT_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(width_q);
    end
    eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
    if (chans_q == 3'd0) begin
      eff_ch = 3'd1;
    end else if (chans_q > 3'd4) begin
      eff_ch = 3'd4;
    end else begin
      eff_ch = chans_q;
    end

    col_inc  = CNT_W'(col_q) + CNT_W'(1);
    row_inc  = {1'b0, row_q} + 17'd1;
    ch_inc   = {1'b0, ch_q} + 3'd1;
    pix_done = ch_inc >= eff_ch;
    row_done = pix_done && (col_inc >= eff_w);
    img_done = row_done && (row_inc >= {1'b0, eff_h});

    col_d   = col_q;
    ch_d    = ch_q;
    row_d   = row_q;
    filt_d  = filt_q;
    await_d = await_q;
    halt_d  = halt_q;

    s1_d           = '0;
    s1_d.data      = filtered_byte_i;
    s1_d.ch        = ch_q;
    s1_d.filt      = filt_q;
    s1_d.first_row = (row_q == 16'd0);
    s1_d.two_out   = (eff_ch == 3'd3) && (ch_q == 2'd2);
    s1_d.img_done  = img_done;
    s1_d.addr      = {col_q, ch_q};

    if (await_q) begin
      if (filtered_byte_i > 8'(F_PAETH)) begin
        s1_d.kind = K_ERR;
      end else begin
        s1_d.kind = K_FILT;
      end
    end else begin
      s1_d.kind = K_PIX;
    end

    if (accept && !halt_q) begin
      if (await_q) begin
        if (filtered_byte_i > 8'(F_PAETH)) begin
          halt_d = 1'b1;
        end else begin
          filt_d  = filtered_byte_i[2:0];
          await_d = 1'b0;
          col_d   = '0;
          ch_d    = 2'd0;
        end
      end else if (pix_done) begin
        ch_d = 2'd0;
        if (row_done) begin
          col_d   = '0;
          await_d = 1'b1;
          row_d   = img_done ? 16'd0 : row_inc[15:0];
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end else begin
        ch_d = ch_inc[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      ch_q       <= 2'd0;
      row_q      <= 16'd0;
      filt_q     <= F_NONE;
      await_q    <= 1'b1;
      halt_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      ch_q       <= ch_d;
      row_q      <= row_d;
      filt_q     <= filt_d;
      await_q    <= await_d;
      halt_q     <= halt_d;
      s1_valid_q <= accept && !halt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign rd_en_o    = accept && !halt_q && !await_q;
  assign rd_addr_o  = {col_q, ch_q};
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign halt_o     = halt_q;

endmodule

>>> rtl/psu_recon.sv
`timescale 1ns / 1ps

module psu_recon (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s1_valid_i,
  input  psu_pkg::s1_t              s1_i,
  input  logic [7:0]                rd_data_i,
  output logic                      wr_en_o,
  output logic [psu_pkg::LS_AW-1:0] wr_addr_o,
  output logic [7:0]                wr_data_o,
  output psu_pkg::push_t            push_o
);

  import psu_pkg::*;

  logic [31:0]        left_q, left_d;
  logic [31:0]        ul_q, ul_d;
  logic [7:0]         a, b, c, pred, val;
  logic [8:0]         avg_sum;
  logic signed [10:0] dpa, dpb, dpc;
  logic [10:0]        pa, pb, pc;
  logic               is_pix;

  always_comb begin
    is_pix  = s1_valid_i && (s1_i.kind == K_PIX);
    a       = left_q[{s1_i.ch, 3'b000} +: 8];
    c       = ul_q[{s1_i.ch, 3'b000} +: 8];
    b       = s1_i.first_row ? 8'd0 : rd_data_i;
    avg_sum = {1'b0, a} + {1'b0, b};

    dpa = $signed({3'b000, b}) - $signed({3'b000, c});
    dpb = $signed({3'b000, a}) - $signed({3'b000, c});
    dpc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa  = (dpa < 0) ? 11'(-dpa) : 11'(dpa);
    pb  = (dpb < 0) ? 11'(-dpb) : 11'(dpb);
    pc  = (dpc < 0) ? 11'(-dpc) : 11'(dpc);

    case (s1_i.filt)
      F_SUB:   pred = a;
      F_UP:    pred = b;
      F_AVG:   pred = avg_sum[8:1];
      F_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = 8'd0;
    endcase
    val = s1_i.data + pred;

    left_d = left_q;
    ul_d   = ul_q;
    if (s1_valid_i && s1_i.kind == K_FILT) begin
      left_d = '0;
      ul_d   = '0;
    end else if (is_pix) begin
      left_d[{s1_i.ch, 3'b000} +: 8] = val;
      ul_d[{s1_i.ch, 3'b000} +: 8]   = b;
    end

    push_o = '0;
    if (s1_valid_i && s1_i.kind == K_ERR) begin
      push_o.n             = 2'd1;
      push_o.r0.run_end    = 1'b1;
      push_o.r0.bad_filter = 1'b1;
    end else if (is_pix) begin
      push_o.r0.pixel = val;
      if (s1_i.two_out) begin
        push_o.n            = 2'd2;
        push_o.r1.pixel     = ALPHA_FILL;
        push_o.r1.run_end   = 1'b1;
        push_o.r1.image_end = s1_i.img_done;
      end else begin
        push_o.n            = 2'd1;
        push_o.r0.run_end   = 1'b1;
        push_o.r0.image_end = s1_i.img_done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ul_q   <= '0;
    end else begin
      left_q <= left_d;
      ul_q   <= ul_d;
    end
  end

  assign wr_en_o   = is_pix;
  assign wr_addr_o = s1_i.addr;
  assign wr_data_o = val;

endmodule

>>> rtl/psu_outq.sv
`timescale 1ns / 1ps

module psu_outq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  psu_pkg::push_t            push_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output psu_pkg::res_t             out_o,
  output logic [psu_pkg::OQ_CW-1:0] count_o
);

  import psu_pkg::*;

  res_t             mem_q [OQ_DEPTH];
  logic [OQ_PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop = (cnt_q != '0) && !out_stall_i;

  always_comb begin
    wp_d  = wp_q + OQ_PW'(push_i.n);
    rp_d  = pop ? rp_q + OQ_PW'(1) : rp_q;
    cnt_d = cnt_q + OQ_CW'(push_i.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wp_q + OQ_PW'(1)] <= push_i.r1;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rp_q];
  assign count_o     = cnt_q;

endmodule

>>> rtl/png_scanline_unfilter_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   filtered_byte_i
// out      output     out_valid_o / out_stall_i pixel_byte_o, run_end_o, image_end_o,
//                                               bad_filter_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One input byte per cycle while in_stall_o is low; results pass through the s1 register and the output queue.
// With three channels each pixel yields four output bytes, so the output port, not the
// input, sets the pace.
// Line store reads on input transaction and writes back on the following cycle.
// Reset clears all control state; the line store is not cleared (row 0 uses zero, not its contents).
// in_stall_o rises when the 4-entry output queue cannot take another two results.

module png_scanline_unfilter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          filtered_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          pixel_byte_o,
  output logic                                run_end_o,
  output logic                                image_end_o,
  output logic                                bad_filter_o
);

  import psu_pkg::*;

  logic             rd_en, wr_en, s1_valid, halt;
  logic [LS_AW-1:0] rd_addr, wr_addr;
  logic [7:0]       rd_data, wr_data;
  s1_t              s1;
  push_t            push;
  res_t             head;
  logic [OQ_CW-1:0] q_count;
  logic [OQ_CW:0]   q_need;

  assign q_need     = {1'b0, q_count} + (OQ_CW + 1)'(push.n);
  assign in_stall_o = q_need > (OQ_CW + 1)'(OQ_DEPTH - 2);

  psu_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .filtered_byte_i (filtered_byte_i),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .s1_valid_o      (s1_valid),
    .s1_o            (s1),
    .halt_o          (halt)
  );

  psu_ram #(
    .WIDTH (8),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  psu_recon u_recon (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push)
  );

  psu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (head),
    .count_o     (q_count)
  );

  assign pixel_byte_o = head.pixel;
  assign run_end_o    = head.run_end;
  assign image_end_o  = head.image_end;
  assign bad_filter_o = head.bad_filter;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("line store read and write hit the same entry");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt |=> !(s1_valid && s1.kind == K_PIX))
    else $error("pixel processed after bad filter");

endmodule

>>> dv/png_unfilter_checker.sv
`timescale 1ns / 1ps

module png_unfilter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     filtered_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     pixel_byte_i,
  input  logic                           run_end_i,
  input  logic                           image_end_i,
  input  logic                           bad_filter_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatch_count_o
);
  import psu_pkg::*;

  logic [7:0]  row_above [LS_DEPTH];
  logic [31:0] left_px;
  logic [31:0] upleft_px;
  logic [2:0]  row_filt;
  int unsigned col_idx;
  int unsigned chan_idx;
  int unsigned row_idx;
  bit          want_filter;
  bit          halted;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned chans_reg;
  res_t        pixel_expect_q [$];
  res_t        head;
  int unsigned mismatches;

  function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    return (pb <= pc) ? b : c;
  endfunction

  function automatic bit field_matches(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic unfilter_byte(input logic [7:0] x);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned ch;
    int unsigned col;
    int unsigned idx;
    int unsigned sh;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  val;
    bit          pix_done;
    bit          row_done;
    bit          img_done;
    if (halted) return;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    n = (chans_reg == 0) ? 1 : ((chans_reg > 4) ? 4 : chans_reg);

    if (want_filter) begin
      if (x > F_PAETH) begin
        halted = 1'b1;
        pixel_expect_q.push_back({8'd0, 1'b1, 1'b0, 1'b1});
        return;
      end
      row_filt    = x[2:0];
      want_filter = 1'b0;
      col_idx     = 0;
      chan_idx    = 0;
      left_px     = '0;
      upleft_px   = '0;
      return;
    end

    ch  = chan_idx & 3;
    col = (col_idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_idx;
    sh  = ch * 8;
    idx = col * 4 + ch;
    a   = left_px[sh +: 8];
    b   = (row_idx > 0) ? row_above[idx] : 8'd0;
    c   = upleft_px[sh +: 8];

    case (row_filt)
      F_SUB:   pred = a;
      F_UP:    pred = b;
      F_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      F_PAETH: pred = paeth_predict(a, b, c);
      default: pred = 8'd0;
    endcase
    val = x + pred;

    row_above[idx]     = val;
    left_px[sh +: 8]   = val;
    upleft_px[sh +: 8] = b;

    pix_done = (ch + 1 >= n);
    row_done = pix_done && (col + 1 >= w);
    img_done = row_done && (row_idx + 1 >= h);

    // RGB input gets an opaque alpha byte after the blue sample
    if (n == 3 && ch == 2) begin
      pixel_expect_q.push_back({val, 1'b0, 1'b0, 1'b0});
      pixel_expect_q.push_back({ALPHA_FILL, 1'b1, img_done, 1'b0});
    end else begin
      pixel_expect_q.push_back({val, 1'b1, img_done, 1'b0});
    end

    if (pix_done) begin
      chan_idx = 0;
      if (row_done) begin
        col_idx     = 0;
        want_filter = 1'b1;
        row_idx     = img_done ? 0 : ((row_idx + 1) & 16'hFFFF);
      end else begin
        col_idx = col + 1;
      end
    end else begin
      chan_idx = ch + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_px     = '0;
      upleft_px   = '0;
      row_filt    = F_NONE;
      col_idx     = 0;
      chan_idx    = 0;
      row_idx     = 0;
      want_filter = 1'b1;
      halted      = 1'b0;
      width_reg   = 1;
      height_reg  = 1;
      chans_reg   = 4;
      mismatches  = 0;
      pixel_expect_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // a transaction on the input uses the registers as they were before this edge
      if (in_valid_i && !in_stall_i) unfilter_byte(filtered_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:    width_reg  = 32'(cfg_wdata_i[12:0]);
          CFG_IMAGE_HEIGHT:   height_reg = 32'(cfg_wdata_i[15:0]);
          CFG_COLOR_CHANNELS: chans_reg  = 32'(cfg_wdata_i[2:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual %s%0h %s%0b %s%0b %s%0b",
                   $time, "pixel=", pixel_byte_i, "run_end=", run_end_i,
                   "image_end=", image_end_i, "bad_filter=", bad_filter_i);
          mismatches++;
        end else begin
          head = pixel_expect_q.pop_front();
          if (!(field_matches("pixel_byte", head.pixel, pixel_byte_i) &
                field_matches("run_end", head.run_end, run_end_i) &
                field_matches("image_end", head.image_end, image_end_i) &
                field_matches("bad_filter", head.bad_filter, bad_filter_i))) begin
            mismatches++;
          end
        end
      end
      pending_o        <= pixel_expect_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> dv/png_scanline_unfilter_top_tb.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_top_tb;
  import psu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 750;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            filtered_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            pixel_byte_o;
  logic                  run_end_o;
  logic                  image_end_o;
  logic                  bad_filter_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycles     = 0;
  int unsigned stall_run  = 0;
  int unsigned item_count = 0;
  bit          steady     = 1'b0;

  png_scanline_unfilter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .filtered_byte_i(filtered_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_byte_o   (pixel_byte_o),
    .run_end_o      (run_end_o),
    .image_end_o    (image_end_o),
    .bad_filter_o   (bad_filter_o)
  );

  png_unfilter_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .filtered_byte_i (filtered_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_byte_i    (pixel_byte_o),
    .run_end_i       (run_end_o),
    .image_end_i     (image_end_o),
    .bad_filter_i    (bad_filter_o),
    .pending_o       (pending),
    .mismatch_count_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] sample_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] edge_byte(input int unsigned k);
    case (k % 4)
      0:       return 8'hFF;
      1:       return 8'h00;
      2:       return 8'h80;
      default: return 8'h01;
    endcase
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run--;
    end else if (out_stall_i || steady) begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b1;
      stall_run = idle_len();
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned g;
    in_valid_i      <= 1'b1;
    filtered_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_count++;
    g = steady ? 0 : idle_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // filter bytes produce no transaction but may still be in the pipe
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_image(input int unsigned w, input int unsigned h,
                               input int unsigned c);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= CFG_DATA_W'(h);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_COLOR_CHANNELS;
    cfg_wdata_i <= CFG_DATA_W'(c);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_row(input int unsigned n);
    push_byte(8'($urandom_range(F_NONE, F_PAETH)));
    repeat (n) push_byte(sample_byte());
  endtask

  // retarget: height may be rewritten between rows of the image
  task automatic stream_image(input int unsigned w, input int unsigned h, input int unsigned c,
                              input bit retarget);
    int unsigned row_bytes;
    int unsigned rows;
    int unsigned hn;
    int unsigned r;
    row_bytes = ((w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w)) *
                ((c == 0) ? 1 : ((c > 4) ? 4 : c));
    rows   = (h == 0) ? 1 : h;
    steady = ($urandom_range(0, 5) == 0);
    for (r = 0; r < rows; r++) begin
      if (retarget && r != 0 && $urandom_range(0, 5) == 0) begin
        hn = $urandom_range(0, r + 3);
        program_image(w, hn, c);
        rows = (hn > r) ? hn : r + 1;
      end
      send_row(row_bytes);
    end
  endtask

  initial begin
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned cur_c;
    int unsigned goal;
    int unsigned r;
    int unsigned k;
    logic [2:0]  f;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_IMAGE_WIDTH;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    filtered_byte_i <= '0;
    out_stall_i     <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one RGBA pixel under the reset register values
    push_byte(8'(F_NONE));
    for (k = 0; k < 4; k++) push_byte(edge_byte(k));

    program_image(2, 4, 2);
    for (r = 0; r < 4; r++) begin
      case (r)
        0:       f = F_PAETH;
        1:       f = F_SUB;
        2:       f = F_UP;
        default: f = F_AVG;
      endcase
      push_byte(8'(f));
      for (k = 0; k < 4; k++) push_byte(edge_byte(r + k));
    end

    // zero width and zero channel count
    program_image(0, 2, 0);
    stream_image(0, 2, 0, 1'b0);

    // tallest image cut short by a height write between rows
    program_image(3, 65535, 4);
    repeat (3) send_row(12);
    program_image(3, 0, 4);
    send_row(12);
    cur_w = 3;
    cur_h = 0;
    cur_c = 4;

    goal = item_count + RANDOM_ITEMS;
    while (item_count < goal) begin
      if ($urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, 99);
        if (k < 3)       cur_w = 0;
        else if (k < 78) cur_w = $urandom_range(1, 6);
        else if (k < 95) cur_w = $urandom_range(7, 24);
        else             cur_w = $urandom_range(25, 64);
        cur_h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        cur_c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        program_image(cur_w, cur_h, cur_c);
      end
      stream_image(cur_w, cur_h, cur_c, 1'b1);
    end

    // invalid filter type on the second row halts the block for good
    steady = 1'b0;
    program_image(2, 3, 3);
    send_row(6);
    push_byte(8'($urandom_range(F_PAETH + 1, 255)));
    repeat (8) push_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/psu_pkg.sv
rtl/psu_ram.sv
rtl/psu_ctrl.sv
rtl/psu_recon.sv
rtl/psu_outq.sv
rtl/png_scanline_unfilter_top.sv
dv/png_unfilter_checker.sv
dv/png_scanline_unfilter_top_tb.sv
